/* sv/sscom_pkg.sv */
// Shared constants and types for the six-step open-loop commutator.
`default_nettype none

package sscom_pkg;

   // Field and port widths
   localparam int SPEED_W           = 21;
   localparam int RATE_W            = 17;
   localparam int TICKS_W           = 24;
   localparam int ANGLE_W           = 12;
   localparam int DUTY_W            = 11;
   localparam int CSR_DATA_W        = 21;
   localparam int REQ_DATA_W        = 24;
   localparam int RSP_DATA_W        = 48;

   // Default number of fraction bits in the angle accumulator
   localparam int FRAC_BITS_DEFAULT = 16;

   // Angles in tenth degrees
   localparam logic [ANGLE_W-1:0] TURN_TENTHS       = 12'd3600;
   localparam logic [ANGLE_W-1:0] SECTOR_TENTHS     = 12'd1200;
   localparam logic [ANGLE_W-1:0] TWO_SECTOR_TENTHS = 12'd2400;

   // PWM compare value at full duty
   localparam logic [DUTY_W-1:0]  PWM_TOP           = 11'd1999;

   // Register map
   typedef enum logic [0:0] {
      CSR_SPEED   = 1'b0,
      CSR_VOLTAGE = 1'b1
   } csr_index_type;

   // Pipeline control handed to a sub-pipeline
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   // Output of one phase
   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              drive;
   } phase_drive_type;

endpackage

`default_nettype wire

/* sv/sscom_turn_reduce.sv */
// Speed times elapsed ticks, reduced modulo one electrical turn over four stages.
`default_nettype none

module sscom_turn_reduce #(
   parameter int FRAC_BITS = sscom_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                                            clock,
   input  wire                                            reset,
   input  sscom_pkg::pipe_ctl_type                        ctl,
   input  wire  [sscom_pkg::TICKS_W-1:0]                  ticks,
   input  wire  signed [sscom_pkg::SPEED_W-1:0]           speed,
   output logic                                           delta_valid,
   output logic [sscom_pkg::ANGLE_W+FRAC_BITS-1:0]        delta
);

   localparam int ACC_W    = sscom_pkg::ANGLE_W + FRAC_BITS;
   localparam int PROD_W   = sscom_pkg::SPEED_W + sscom_pkg::TICKS_W;
   localparam int XW       = PROD_W - FRAC_BITS;
   localparam int XL_W     = 16;
   localparam int XH_W     = XW - XL_W;
   localparam longint TURN_L = longint'(sscom_pkg::TURN_TENTHS);
   // weight of the upper part modulo a turn: 2^16 mod 3600
   localparam longint LOW_WEIGHT_L = (longint'(1) << XL_W) % TURN_L;
   localparam int LOW_WEIGHT_W = $clog2(LOW_WEIGHT_L + 1);
   localparam logic [LOW_WEIGHT_W-1:0] LOW_WEIGHT = LOW_WEIGHT_W'(LOW_WEIGHT_L);
   localparam int YW_BASE  = (XH_W + LOW_WEIGHT_W > XL_W) ? XH_W + LOW_WEIGHT_W : XL_W;
   localparam int YW       = YW_BASE + 1;
   // reciprocal of a turn, scaled by 2^YW
   localparam longint RECIP_L = (longint'(1) << YW) / TURN_L;
   localparam int RECIP_W  = YW - 11;
   localparam int Q_W      = YW - 11;
   localparam int QP_W     = YW + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
   // flipping the sign bit of the upper part adds 2^(XH_W-1); this is its weight mod a turn
   localparam longint BIAS_L = ((longint'(1) << (XH_W - 1)) * LOW_WEIGHT_L) % TURN_L;
   localparam logic [sscom_pkg::ANGLE_W-1:0] BIAS_MOD = sscom_pkg::ANGLE_W'(BIAS_L);
   localparam logic [sscom_pkg::ANGLE_W-1:0] BIAS_COMP = sscom_pkg::TURN_TENTHS - BIAS_MOD;
   localparam logic [ACC_W:0] TURN_FIXED = (ACC_W+1)'(sscom_pkg::TURN_TENTHS) << FRAC_BITS;

   // product stage
   logic signed [sscom_pkg::TICKS_W:0] ticks_s;
   logic signed [PROD_W-1:0]           prod_in;
   logic signed [PROD_W-1:0]           prod_ff;
   logic                               v_prod_ff;

   // fold stage
   logic [XL_W-1:0]      xl;
   logic [XH_W-1:0]      xh_u;
   logic [YW-1:0]        fold_in;
   logic [YW-1:0]        fold_ff;
   logic [FRAC_BITS-1:0] frac_fold_ff;
   logic                 v_fold_ff;

   // quotient stage
   logic [QP_W-1:0]      qprod;
   logic [Q_W-1:0]       quot_ff;
   logic [YW-1:0]        fold_q_ff;
   logic [FRAC_BITS-1:0] frac_q_ff;
   logic                 v_quot_ff;

   // remainder stage
   logic [YW-1:0]                    rem_full;
   logic [sscom_pkg::ANGLE_W:0]      rem;
   logic [sscom_pkg::ANGLE_W-1:0]    rem1;
   logic [sscom_pkg::ANGLE_W-1:0]    rem2;
   logic [ACC_W-1:0]                 delta_in;
   logic [ACC_W-1:0]                 delta_ff;
   logic                             delta_valid_ff;

   // signed 21 x unsigned 24 product
   assign ticks_s = {1'b0, ticks};
   assign prod_in = PROD_W'(speed) * PROD_W'(ticks_s);

   // floor(prod / 2^F) split in two; the upper part is biased to unsigned
   assign xl      = prod_ff[FRAC_BITS+XL_W-1:FRAC_BITS];
   assign xh_u    = {~prod_ff[PROD_W-1], prod_ff[PROD_W-2:FRAC_BITS+XL_W]};
   assign fold_in = YW'(xh_u) * YW'(LOW_WEIGHT) + YW'(xl);

   // quotient estimate, at most one short
   assign qprod = QP_W'(fold_ff) * QP_W'(RECIP);

   // remainder, one correction, then remove the bias
   assign rem_full = fold_q_ff - YW'(quot_ff) * YW'(sscom_pkg::TURN_TENTHS);
   assign rem      = rem_full[sscom_pkg::ANGLE_W:0];
   assign rem1     = (rem >= {1'b0, sscom_pkg::TURN_TENTHS})
                     ? sscom_pkg::ANGLE_W'(rem - {1'b0, sscom_pkg::TURN_TENTHS})
                     : rem[sscom_pkg::ANGLE_W-1:0];
   assign rem2     = (rem1 >= BIAS_MOD) ? rem1 - BIAS_MOD : rem1 + BIAS_COMP;
   assign delta_in = {rem2, frac_q_ff};

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_prod_ff      <= 1'b0;
         v_fold_ff      <= 1'b0;
         v_quot_ff      <= 1'b0;
         delta_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         v_prod_ff      <= ctl.valid;
         v_fold_ff      <= v_prod_ff;
         v_quot_ff      <= v_fold_ff;
         delta_valid_ff <= v_quot_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff      <= prod_in;
         fold_ff      <= fold_in;
         frac_fold_ff <= prod_ff[FRAC_BITS-1:0];
         quot_ff      <= qprod[YW+Q_W-1:YW];
         fold_q_ff    <= fold_ff;
         frac_q_ff    <= frac_fold_ff;
         delta_ff     <= delta_in;
      end
   end

   assign delta_valid = delta_valid_ff;
   assign delta       = delta_ff;

`ifndef NO_ASSERTIONS
   // quotient estimate never more than one short
   a_quot_close: assert property (@(posedge clock) disable iff (reset)
      v_quot_ff |-> (rem_full < YW'(2) * YW'(sscom_pkg::TURN_TENTHS)))
      else $error("quotient estimate off by more than one");

   // every step handed on lies within one turn
   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      delta_valid_ff |-> ({1'b0, delta_ff} < TURN_FIXED))
      else $error("reduced step outside one turn");
`endif

endmodule

`default_nettype wire

/* sv/sscom_sector_map.sv */
// Maps the electrical angle to duty and drive enable of phases U, V and W.
`default_nettype none

module sscom_sector_map (
   input  wire  [sscom_pkg::ANGLE_W-1:0] angle,
   input  wire  [sscom_pkg::DUTY_W-1:0]  duty_hi,
   output sscom_pkg::phase_drive_type    u_out,
   output sscom_pkg::phase_drive_type    v_out,
   output sscom_pkg::phase_drive_type    w_out
);

   logic [sscom_pkg::ANGLE_W-1:0] v_angle;
   logic [sscom_pkg::ANGLE_W-1:0] w_angle;

   // lower sector drives at duty_hi, middle floats, upper drives low
   function automatic sscom_pkg::phase_drive_type map_phase(
      input logic [sscom_pkg::ANGLE_W-1:0] ph,
      input logic [sscom_pkg::DUTY_W-1:0]  hi
   );
      sscom_pkg::phase_drive_type res;
      if (ph < sscom_pkg::SECTOR_TENTHS) begin
         res.duty  = hi;
         res.drive = 1'b1;
      end else if (ph < sscom_pkg::TWO_SECTOR_TENTHS) begin
         res.duty  = '0;
         res.drive = 1'b0;
      end else begin
         res.duty  = '0;
         res.drive = 1'b1;
      end
      return res;
   endfunction

   // phase offsets of +120 and +240 degrees, wrapped into one turn
   assign v_angle = (angle < sscom_pkg::TWO_SECTOR_TENTHS)
                    ? angle + sscom_pkg::SECTOR_TENTHS
                    : angle - sscom_pkg::TWO_SECTOR_TENTHS;
   assign w_angle = (angle < sscom_pkg::SECTOR_TENTHS)
                    ? angle + sscom_pkg::TWO_SECTOR_TENTHS
                    : angle - sscom_pkg::SECTOR_TENTHS;

   assign u_out = map_phase(angle, duty_hi);
   assign v_out = map_phase(v_angle, duty_hi);
   assign w_out = map_phase(w_angle, duty_hi);

endmodule

`default_nettype wire

/* sv/six_step_open_loop_commutator.sv */
// Throughput: one word per cycle; seven register stages (input, product, fold,
// quotient, remainder, angle accumulator, result) advance together and stall as one.
// Reset (synchronous, active high) clears the angle to 0, speed and duty to 0,
// and empties the pipeline.
`default_nettype none

module six_step_open_loop_commutator #(
   parameter int FRAC_BITS = sscom_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // input stream
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [sscom_pkg::REQ_DATA_W-1:0]       req_tdata,  // [23:0] elapsed_ticks
   // result stream
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // [11:0] angle_tenths, [22:12] u_duty, [33:23] v_duty, [44:34] w_duty,
   // [45] u_drive, [46] v_drive, [47] w_drive
   output logic [sscom_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // configuration write
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [0:0]                             csr_index,
   input  wire  [sscom_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int ACC_W     = sscom_pkg::ANGLE_W + FRAC_BITS;
   localparam int RATE_FRAC = sscom_pkg::RATE_W - 1;
   localparam int SCALED_W  = sscom_pkg::DUTY_W + RATE_FRAC;
   localparam logic [ACC_W:0] TURN_FIXED = (ACC_W+1)'(sscom_pkg::TURN_TENTHS) << FRAC_BITS;

   // configuration
   logic signed [sscom_pkg::SPEED_W-1:0] speed_ff;
   logic [sscom_pkg::DUTY_W-1:0]         duty_hi_ff;

   // pipeline control
   logic                                 advance;
   logic                                 in_valid_ff;
   logic [sscom_pkg::TICKS_W-1:0]        ticks_ff;
   sscom_pkg::pipe_ctl_type              reduce_ctl;

   // accumulator
   logic                                 delta_valid;
   logic [ACC_W-1:0]                     delta;
   logic [ACC_W:0]                       acc_sum;
   logic [ACC_W-1:0]                     acc_in;
   logic [ACC_W-1:0]                     acc_ff;
   logic                                 acc_valid_ff;

   // result
   sscom_pkg::phase_drive_type           u_map;
   sscom_pkg::phase_drive_type           v_map;
   sscom_pkg::phase_drive_type           w_map;
   logic                                 rsp_valid_ff;
   logic [sscom_pkg::ANGLE_W-1:0]        rsp_angle_ff;
   sscom_pkg::phase_drive_type           rsp_u_ff;
   sscom_pkg::phase_drive_type           rsp_v_ff;
   sscom_pkg::phase_drive_type           rsp_w_ff;

   // duty at full drive, saturating at PWM_TOP
   function automatic logic [sscom_pkg::DUTY_W-1:0] duty_from_rate(
      input logic [sscom_pkg::RATE_W-1:0] rate
   );
      logic [SCALED_W-1:0] scaled;
      scaled = SCALED_W'(sscom_pkg::PWM_TOP) * SCALED_W'(rate[RATE_FRAC-1:0]);
      if (rate[RATE_FRAC]) begin
         return sscom_pkg::PWM_TOP;
      end
      return scaled[SCALED_W-1:RATE_FRAC];
   endfunction

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= '0;
         duty_hi_ff <= '0;
      end else if (csr_valid) begin
         unique case (sscom_pkg::csr_index_type'(csr_index))
            sscom_pkg::CSR_SPEED: begin
               speed_ff <= csr_data[sscom_pkg::SPEED_W-1:0];
            end
            sscom_pkg::CSR_VOLTAGE: begin
               duty_hi_ff <= duty_from_rate(csr_data[sscom_pkg::RATE_W-1:0]);
            end
         endcase
      end
   end

   // whole pipeline moves when the result register is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ticks_ff <= req_tdata[sscom_pkg::TICKS_W-1:0];
      end
   end

   assign reduce_ctl.advance = advance;
   assign reduce_ctl.valid   = in_valid_ff;

   sscom_turn_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_turn_reduce (
      .clock       (clock),
      .reset       (reset),
      .ctl         (reduce_ctl),
      .ticks       (ticks_ff),
      .speed       (speed_ff),
      .delta_valid (delta_valid),
      .delta       (delta)
   );

   // angle accumulator: both terms below one turn, one subtract wraps
   assign acc_sum = {1'b0, acc_ff} + {1'b0, delta};
   assign acc_in  = (acc_sum >= TURN_FIXED) ? ACC_W'(acc_sum - TURN_FIXED)
                                            : acc_sum[ACC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         acc_valid_ff <= 1'b0;
      end else if (advance) begin
         acc_valid_ff <= delta_valid;
         if (delta_valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   // sector decode of the current angle
   sscom_sector_map u_sector_map (
      .angle   (acc_ff[ACC_W-1:FRAC_BITS]),
      .duty_hi (duty_hi_ff),
      .u_out   (u_map),
      .v_out   (v_map),
      .w_out   (w_map)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= acc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_angle_ff <= acc_ff[ACC_W-1:FRAC_BITS];
         rsp_u_ff     <= u_map;
         rsp_v_ff     <= v_map;
         rsp_w_ff     <= w_map;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_w_ff.drive, rsp_v_ff.drive, rsp_u_ff.drive,
                        rsp_w_ff.duty, rsp_v_ff.duty, rsp_u_ff.duty, rsp_angle_ff};

`ifndef NO_ASSERTIONS
   // accumulated angle stays within one turn
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, acc_ff} < TURN_FIXED)
      else $error("angle accumulator outside one turn");

   // angle only moves when a step passes the accumulator
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && delta_valid) |=> $stable(acc_ff))
      else $error("angle changed without a step");

   // six-step drive: exactly two phases driven in every result word
   a_two_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones({rsp_u_ff.drive, rsp_v_ff.drive, rsp_w_ff.drive}) == 2))
      else $error("drive pattern is not two of three phases");

   // result angle is the accumulator value of the word that moved on
   a_rsp_angle: assert property (@(posedge clock) disable iff (reset)
      (advance && acc_valid_ff) |=> (rsp_angle_ff == $past(acc_ff[ACC_W-1:FRAC_BITS])))
      else $error("result angle does not match accumulator");
`endif

endmodule

`default_nettype wire
